@@ hw/rtl/cssd_pkg.sv @@
package cssd_pkg;

  // operand widths of the eigenvalue test
  localparam int LW   = 33;   // trial eigenvalue, 0 .. 2^32
  localparam int SW   = 34;   // doubled diagonal / negated off-diagonal sums
  localparam int DW   = 36;   // 2L - s
  localparam int PW   = 2 * DW;
  localparam int CW   = 74;   // 2x2 cofactors
  localparam int CLO  = 37;   // low split of a cofactor
  localparam int DETW = 112;  // 3x3 determinant
  localparam int QW   = 32;   // quotient bits

  localparam int NPROBE = 34; // low bound, high bound, 32 bisection steps

  localparam logic [1:0] EIG_SEARCH = 2'd0;
  localparam logic [1:0] EIG_NEG    = 2'd1;
  localparam logic [1:0] EIG_ZERO   = 2'd2;

  localparam logic [1:0] PROBE_LO  = 2'd0;
  localparam logic [1:0] PROBE_HI  = 2'd1;
  localparam logic [1:0] PROBE_MID = 2'd2;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_EPS  = 1'b1;

  localparam logic [31:0]   Q_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0]   Q_MINUS_ONE = 32'hFFFF_0000;
  localparam logic [LW-1:0] L_TOP       = 33'h1_0000_0000;

  typedef struct packed {
    logic                 vld;
    logic                 full;
    logic                 neg_all;
    logic [1:0]           eig;
    logic [LW-1:0]        lo;
    logic [LW-1:0]        hi;
    logic signed [SW-1:0] s0;
    logic signed [SW-1:0] s1;
    logic signed [SW-1:0] s2;
    logic signed [SW-1:0] m01;
    logic signed [SW-1:0] m02;
    logic signed [SW-1:0] m12;
    logic [31:0]          g00;
  } cssd_item_t;

  typedef struct packed {
    logic          vld;
    logic          full;
    logic          neg_all;
    logic [1:0]    eig;
    logic [LW-1:0] dn;
    logic [LW-1:0] de;
    logic [LW-1:0] rem_n;
    logic [LW-1:0] rem_e;
    logic [QW-1:0] q_n;
    logic [QW-1:0] q_e;
  } cssd_div_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] rho_n;
    logic [31:0] rho_t;
  } cssd_rslt_t;

endpackage

@@ hw/rtl/cssd_if.sv @@
interface cssd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] g_r0c0;
  logic signed [31:0] g_r0c1;
  logic signed [31:0] g_r0c2;
  logic signed [31:0] g_r1c0;
  logic signed [31:0] g_r1c1;
  logic signed [31:0] g_r1c2;
  logic signed [31:0] g_r2c0;
  logic signed [31:0] g_r2c1;
  logic signed [31:0] g_r2c2;
  modport source (output valid, g_r0c0, g_r0c1, g_r0c2, g_r1c0, g_r1c1, g_r1c2,
                  g_r2c0, g_r2c1, g_r2c2, input ready);
  modport sink (input valid, g_r0c0, g_r0c1, g_r0c2, g_r1c0, g_r1c1, g_r1c2,
                g_r2c0, g_r2c1, g_r2c2, output ready);
endinterface

interface cssd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rho_normal;
  logic signed [31:0] rho_tangent_one;
  logic signed [31:0] rho_tangent_two;
  modport source (output valid, rho_normal, rho_tangent_one, rho_tangent_two,
                  input ready);
  modport sink (input valid, rho_normal, rho_tangent_one, rho_tangent_two,
                output ready);
endinterface

@@ hw/rtl/cssd_probe.sv @@
// One PSD test of 2L*I - Gs at a trial L, five register stages.
module cssd_probe import cssd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [1:0] kind,
  input  cssd_item_t item_i,
  output cssd_item_t item_o
);

  // split partial product widths
  localparam int PAW = DW + CW - CLO;
  localparam int PBW = DW + CLO + 1;

  // stage A: pick L, form diagonal
  cssd_item_t           a_item_r;
  logic [LW-1:0]        a_l_r;
  logic                 a_act_r;
  logic signed [DW-1:0] a_d0_r, a_d1_r, a_d2_r;

  logic [LW-1:0]        span, l_nxt;
  logic signed [DW-1:0] two_l;

  always_comb begin
    span = item_i.hi - item_i.lo;
    case (kind)
      PROBE_LO: l_nxt = item_i.lo;
      PROBE_HI: l_nxt = item_i.hi;
      default:  l_nxt = item_i.lo + (span >> 1);
    endcase
    two_l = $signed({2'b00, l_nxt, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_item_r <= '0;
      a_act_r  <= 1'b0;
    end else if (adv) begin
      a_item_r <= item_i;
      a_act_r  <= item_i.vld && (item_i.eig == EIG_SEARCH) &&
                  ((kind != PROBE_MID) || (span > LW'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_l_r  <= l_nxt;
      a_d0_r <= two_l - DW'(item_i.s0);
      a_d1_r <= two_l - DW'(item_i.s1);
      a_d2_r <= two_l - DW'(item_i.s2);
    end
  end

  // stage B: pairwise products
  cssd_item_t           b_item_r;
  logic [LW-1:0]        b_l_r;
  logic                 b_act_r;
  logic signed [DW-1:0] b_d0_r;
  logic [2:0]           b_neg_r;
  logic signed [PW-1:0] b_p1_r, b_p2_r, b_p3_r, b_p4_r, b_p5_r;
  logic signed [PW-1:0] b_p6_r, b_p7_r, b_p8_r, b_p9_r, b_p10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_item_r <= '0;
      b_act_r  <= 1'b0;
    end else if (adv) begin
      b_item_r <= a_item_r;
      b_act_r  <= a_act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_l_r   <= a_l_r;
      b_d0_r  <= a_d0_r;
      b_neg_r <= {a_d2_r[DW-1], a_d1_r[DW-1], a_d0_r[DW-1]};
      b_p1_r  <= PW'(a_d1_r) * PW'(a_d2_r);
      b_p2_r  <= PW'(a_item_r.m12) * PW'(a_item_r.m12);
      b_p3_r  <= PW'(a_d0_r) * PW'(a_d1_r);
      b_p4_r  <= PW'(a_item_r.m01) * PW'(a_item_r.m01);
      b_p5_r  <= PW'(a_d0_r) * PW'(a_d2_r);
      b_p6_r  <= PW'(a_item_r.m02) * PW'(a_item_r.m02);
      b_p7_r  <= PW'(a_item_r.m01) * PW'(a_d2_r);
      b_p8_r  <= PW'(a_item_r.m12) * PW'(a_item_r.m02);
      b_p9_r  <= PW'(a_item_r.m01) * PW'(a_item_r.m12);
      b_p10_r <= PW'(a_d1_r) * PW'(a_item_r.m02);
    end
  end

  // stage C: cofactors and minor signs
  cssd_item_t           c_item_r;
  logic [LW-1:0]        c_l_r;
  logic                 c_act_r;
  logic signed [DW-1:0] c_d0_r;
  logic                 c_ok_blk_r, c_ok_min_r;
  logic signed [CW-1:0] c_c0_r, c_c1_r, c_c2_r;

  logic signed [CW-1:0] c0, mn01, mn02;

  always_comb begin
    c0   = CW'(b_p1_r) - CW'(b_p2_r);
    mn01 = CW'(b_p3_r) - CW'(b_p4_r);
    mn02 = CW'(b_p5_r) - CW'(b_p6_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_item_r <= '0;
      c_act_r  <= 1'b0;
    end else if (adv) begin
      c_item_r <= b_item_r;
      c_act_r  <= b_act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_l_r      <= b_l_r;
      c_d0_r     <= b_d0_r;
      c_ok_blk_r <= !b_neg_r[1] && !b_neg_r[2] && !c0[CW-1];
      c_ok_min_r <= !b_neg_r[0] && !mn01[CW-1] && !mn02[CW-1];
      c_c0_r     <= c0;
      c_c1_r     <= CW'(b_p7_r) - CW'(b_p8_r);
      c_c2_r     <= CW'(b_p9_r) - CW'(b_p10_r);
    end
  end

  // stage D: cofactor expansion, split partial products
  cssd_item_t                    d_item_r;
  logic [LW-1:0]                 d_l_r;
  logic                          d_act_r;
  logic                          d_ok_blk_r, d_ok_min_r;
  logic signed [PAW-1:0]         d_pa0_r, d_pa1_r, d_pa2_r;
  logic signed [PBW-1:0]         d_pb0_r, d_pb1_r, d_pb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_item_r <= '0;
      d_act_r  <= 1'b0;
    end else if (adv) begin
      d_item_r <= c_item_r;
      d_act_r  <= c_act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_l_r      <= c_l_r;
      d_ok_blk_r <= c_ok_blk_r;
      d_ok_min_r <= c_ok_min_r;
      d_pa0_r    <= PAW'(c_d0_r) * PAW'($signed(c_c0_r[CW-1:CLO]));
      d_pb0_r    <= PBW'(c_d0_r) * $signed({1'b0, c_c0_r[CLO-1:0]});
      d_pa1_r    <= PAW'(c_item_r.m01) * PAW'($signed(c_c1_r[CW-1:CLO]));
      d_pb1_r    <= PBW'(c_item_r.m01) * $signed({1'b0, c_c1_r[CLO-1:0]});
      d_pa2_r    <= PAW'(c_item_r.m02) * PAW'($signed(c_c2_r[CW-1:CLO]));
      d_pb2_r    <= PBW'(c_item_r.m02) * $signed({1'b0, c_c2_r[CLO-1:0]});
    end
  end

  // output stage: determinant sign, bound or search-state update
  logic signed [DETW-1:0] t0, t1, t2, det;
  logic                   psd;
  cssd_item_t             o_nxt, o_r;

  always_comb begin
    t0  = (DETW'(d_pa0_r) <<< CLO) + DETW'(d_pb0_r);
    t1  = (DETW'(d_pa1_r) <<< CLO) + DETW'(d_pb1_r);
    t2  = (DETW'(d_pa2_r) <<< CLO) + DETW'(d_pb2_r);
    det = t0 - t1 + t2;
    psd = d_ok_blk_r && (!d_item_r.full || (d_ok_min_r && !det[DETW-1]));
    o_nxt = d_item_r;
    if (d_act_r) begin
      case (kind)
        PROBE_LO: if (psd) o_nxt.eig = EIG_NEG;
        PROBE_HI: if (!psd) o_nxt.eig = EIG_ZERO;
        default: begin
          if (psd) o_nxt.hi = d_l_r;
          else     o_nxt.lo = d_l_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_r <= '0;
    else if (adv) o_r <= o_nxt;
  end

  assign item_o = o_r;

endmodule

@@ hw/rtl/cssd_recip.sv @@
// Two restoring dividers 2^32 / D, one quotient bit per stage, plus output select.
module cssd_recip import cssd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  cssd_item_t item_i,
  output cssd_rslt_t rslt_o
);

  cssd_div_t div_r [0:QW];
  cssd_div_t div0;

  always_comb begin
    div0.vld     = item_i.vld;
    div0.full    = item_i.full;
    div0.neg_all = item_i.neg_all;
    div0.eig     = item_i.eig;
    div0.dn      = {1'b0, item_i.g00};
    div0.de      = item_i.hi;
    div0.rem_n   = LW'(1);
    div0.rem_e   = LW'(1);
    div0.q_n     = '0;
    div0.q_e     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) div_r[0] <= '0;
    else if (adv) div_r[0] <= div0;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    cssd_div_t     nxt;
    logic [LW-1:0] rs_n, rs_e;

    always_comb begin
      nxt  = div_r[k-1];
      rs_n = {div_r[k-1].rem_n[LW-2:0], 1'b0};
      rs_e = {div_r[k-1].rem_e[LW-2:0], 1'b0};
      if (rs_n >= div_r[k-1].dn) begin
        nxt.rem_n = rs_n - div_r[k-1].dn;
        nxt.q_n   = {div_r[k-1].q_n[QW-2:0], 1'b1};
      end else begin
        nxt.rem_n = rs_n;
        nxt.q_n   = {div_r[k-1].q_n[QW-2:0], 1'b0};
      end
      if (rs_e >= div_r[k-1].de) begin
        nxt.rem_e = rs_e - div_r[k-1].de;
        nxt.q_e   = {div_r[k-1].q_e[QW-2:0], 1'b1};
      end else begin
        nxt.rem_e = rs_e;
        nxt.q_e   = {div_r[k-1].q_e[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) div_r[k] <= '0;
      else if (adv) div_r[k] <= nxt;
    end
  end

  cssd_div_t   fin;
  logic [31:0] rec_n, rec_e, eig_step;

  always_comb begin
    fin   = div_r[QW];
    rec_n = (fin.dn <= LW'(2)) ? Q_MAX : fin.q_n;
    rec_e = (fin.de <= LW'(2)) ? Q_MAX : fin.q_e;
    case (fin.eig)
      EIG_NEG:  eig_step = Q_MINUS_ONE;
      EIG_ZERO: eig_step = '0;
      default:  eig_step = rec_e;
    endcase
    rslt_o.vld = fin.vld;
    if (fin.full) begin
      rslt_o.rho_n = eig_step;
      rslt_o.rho_t = eig_step;
    end else if (fin.neg_all) begin
      rslt_o.rho_n = Q_MINUS_ONE;
      rslt_o.rho_t = Q_MINUS_ONE;
    end else begin
      rslt_o.rho_n = rec_n;
      rslt_o.rho_t = eig_step;
    end
  end

endmodule

@@ hw/rtl/contact_step_size_from_delassus.sv @@
// Contact step sizes from a 3x3 Delassus matrix. Each input word carries the nine
// signed Q16.16 entries; each output word carries the normal and the two (equal)
// tangential step sizes in Q16.16, -1.0 when invalid. The largest eigenvalue of the
// symmetric part is found by bisection on the Q16.16 grid with an exact PSD test,
// so the step is floor(2^32 / ceil(lambda)), saturated to 0x7FFFFFFF, and 0 above
// an eigenvalue of 65536.0. The block is fully pipelined: it takes one word per
// cycle while the output does not stall; each word passes through 1 input stage,
// 34 eigenvalue tests of 5 stages each, 33 divider stages and 1 output register, the
// depth set by the 32 bisection steps and 32 bit-serial quotient stages. A stall on
// the output freezes the whole pipe; ready at the input follows it directly.
// Registers (APB, word addressed by paddr[2]): 0x0 full_spectral_mode, 0x4
// eigen_threshold (reset 1). Write them only while the pipe is empty.
module contact_step_size_from_delassus import cssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cssd_in_if.sink     in_word,
  cssd_out_if.source  out_word,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic        mode_r;
  logic [30:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      eps_r  <= 31'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        REG_MODE: mode_r <= cfg_pwdata[0];
        REG_EPS:  eps_r  <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MODE: cfg_prdata = {31'b0, mode_r};
      REG_EPS:  cfg_prdata = {1'b0, eps_r};
      default:  cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // whole pipe moves when the output register is free or being drained
  cssd_rslt_t out_r;
  logic       adv;

  assign adv           = !out_r.vld || out_word.ready;
  assign in_word.ready = adv;

  // input stage: symmetrize (doubled), note the small-G00 case
  cssd_item_t item_nxt, item0_r;

  always_comb begin
    item_nxt.vld     = in_word.valid;
    item_nxt.full    = mode_r;
    item_nxt.neg_all = !mode_r &&
                       ($signed({in_word.g_r0c0[31], in_word.g_r0c0}) <=
                        $signed({2'b00, eps_r}));
    item_nxt.eig     = EIG_SEARCH;
    item_nxt.lo      = {2'b00, eps_r};
    item_nxt.hi      = L_TOP;
    item_nxt.s0      = {in_word.g_r0c0[31], in_word.g_r0c0, 1'b0};
    item_nxt.s1      = {in_word.g_r1c1[31], in_word.g_r1c1, 1'b0};
    item_nxt.s2      = {in_word.g_r2c2[31], in_word.g_r2c2, 1'b0};
    item_nxt.m01     = -(SW'(in_word.g_r0c1) + SW'(in_word.g_r1c0));
    item_nxt.m02     = -(SW'(in_word.g_r0c2) + SW'(in_word.g_r2c0));
    item_nxt.m12     = -(SW'(in_word.g_r1c2) + SW'(in_word.g_r2c1));
    item_nxt.g00     = in_word.g_r0c0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) item0_r <= '0;
    else if (adv) item0_r <= item_nxt;
  end

  // eigenvalue search: test at eps, test at 65536.0, then 32 bisection steps
  cssd_item_t chain [0:NPROBE];

  assign chain[0] = item0_r;

  for (genvar i = 0; i < NPROBE; i++) begin : g_probe
    localparam logic [1:0] KIND = (i == 0) ? PROBE_LO :
                                  (i == 1) ? PROBE_HI : PROBE_MID;
    cssd_probe u_probe (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .kind   (KIND),
      .item_i (chain[i]),
      .item_o (chain[i+1])
    );
  end

  // reciprocals and final select
  cssd_rslt_t rslt;

  cssd_recip u_recip (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item_i (chain[NPROBE]),
    .rslt_o (rslt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_r <= '0;
    else if (adv) out_r <= rslt;
  end

  assign out_word.valid           = out_r.vld;
  assign out_word.rho_normal      = out_r.rho_n;
  assign out_word.rho_tangent_one = out_r.rho_t;
  assign out_word.rho_tangent_two = out_r.rho_t;

endmodule

@@ dv/tb_contact_step_size_from_delassus.sv @@
module tb_contact_step_size_from_delassus;
  import cssd_pkg::*;

  // ---------------------------------------------------------------------------
  // Types: one matrix word in, three step sizes out
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [31:0] g [9];   // row-major g_r0c0 .. g_r2c2
  } mtx_t;

  typedef struct {
    logic [31:0] rn;
    logic [31:0] rt1;
    logic [31:0] rt2;
  } steps_t;

  // directed row: matrix plus an optional hand-typed expectation
  typedef struct {
    logic [31:0] g [9];
    bit          typed;
    steps_t      want;
  } drow_t;

  localparam longint RECIP_NUM = 64'sd4294967296;   // 2^32, also bisection ceiling
  localparam int     PIPE_LAT  = 205;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic [31:0] TOPV  = 32'h7FFF_FFFF;
  localparam logic [31:0] BOTV  = 32'h8000_0000;

  localparam logic [2:0] ADDR_MODE = {1'b0, REG_MODE, 1'b0} << 1;
  localparam logic [2:0] ADDR_EPS  = {1'b0, REG_EPS, 1'b0} << 1;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT hookup
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cssd_in_if  in_word ();
  cssd_out_if out_word ();

  contact_step_size_from_delassus dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word.sink),
    .out_word    (out_word.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the block's registers, as seen by the predictor
  bit          mode_sh = 1'b0;
  logic [30:0] eps_sh  = 31'd1;

  steps_t steps_q [$];   // expected step sizes, oldest first
  int     errors = 0;
  bit     quiet  = 1'b0; // no idling on either side while set

  // ---------------------------------------------------------------------------
  // Step-size predictor
  // ---------------------------------------------------------------------------

  // Is 2L*I - (G + G^T) positive semidefinite? sv: doubled diagonal, then
  // off-diagonal sums (0,1), (0,2), (1,2). Split mode tests only rows 1..2.
  function automatic bit lambda_bounded(input longint sv [6], input longint l,
                                        input bit full);
    logic signed [127:0] d0, d1, d2, m01, m02, m12, det;
    d0  = 2 * l - sv[0];
    d1  = 2 * l - sv[1];
    d2  = 2 * l - sv[2];
    m01 = -sv[3];
    m02 = -sv[4];
    m12 = -sv[5];
    if (d1 < 0 || d2 < 0) return 1'b0;
    if (d1 * d2 - m12 * m12 < 0) return 1'b0;
    if (!full) return 1'b1;
    if (d0 < 0) return 1'b0;
    if (d0 * d1 - m01 * m01 < 0) return 1'b0;
    if (d0 * d2 - m02 * m02 < 0) return 1'b0;
    det = d0 * d1 * d2 + 2 * m01 * m12 * m02
          - d0 * m12 * m12 - d1 * m02 * m02 - d2 * m01 * m01;
    return det >= 0;
  endfunction

  function automatic longint q_recip(input longint lc);
    longint r;
    r = RECIP_NUM / lc;
    return (r > longint'(TOPV)) ? longint'(TOPV) : r;
  endfunction

  // reciprocal of ceil(lambda_max) on the Q16.16 grid, -1.0 at or below eps, 0 above 65536.0
  function automatic longint eig_step(input longint sv [6], input bit full,
                                      input longint eps);
    longint lo, hi, mid;
    lo = eps;
    hi = RECIP_NUM;
    if (lambda_bounded(sv, lo, full)) return longint'($signed(Q_MINUS_ONE));
    if (!lambda_bounded(sv, hi, full)) return 0;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (lambda_bounded(sv, mid, full)) hi = mid;
      else lo = mid;
    end
    return q_recip(hi);
  endfunction

  function automatic steps_t predict_steps(input mtx_t m);
    longint g [9];
    longint sv [6];
    longint eps, rn, rt;
    steps_t r;
    for (int i = 0; i < 9; i++) g[i] = longint'($signed(m.g[i]));
    eps   = longint'(eps_sh);
    sv[0] = 2 * g[0];
    sv[1] = 2 * g[4];
    sv[2] = 2 * g[8];
    sv[3] = g[1] + g[3];
    sv[4] = g[2] + g[6];
    sv[5] = g[5] + g[7];
    if (mode_sh) begin
      rn = eig_step(sv, 1'b1, eps);
      rt = rn;
    end else if (g[0] <= eps) begin
      // small G00 kills the whole word, not just the normal step
      rn = longint'($signed(Q_MINUS_ONE));
      rt = rn;
    end else begin
      rn = q_recip(g[0]);
      rt = eig_step(sv, 1'b0, eps);
    end
    r.rn  = rn[31:0];
    r.rt1 = rt[31:0];
    r.rt2 = rt[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then long
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: gap, present word, hold until taken; predict on acceptance
  // ---------------------------------------------------------------------------
  task automatic send_word(input mtx_t m, input bit typed, input steps_t want);
    int n;
    n = idle_len();
    @(negedge clk);
    repeat (n) begin
      in_word.valid = 1'b0;
      @(negedge clk);
    end
    in_word.g_r0c0 = m.g[0];
    in_word.g_r0c1 = m.g[1];
    in_word.g_r0c2 = m.g[2];
    in_word.g_r1c0 = m.g[3];
    in_word.g_r1c1 = m.g[4];
    in_word.g_r1c2 = m.g[5];
    in_word.g_r2c0 = m.g[6];
    in_word.g_r2c1 = m.g[7];
    in_word.g_r2c2 = m.g[8];
    in_word.valid  = 1'b1;
    do @(posedge clk); while (!in_word.ready);
    steps_q.push_back(typed ? want : predict_steps(m));
  endtask

  task automatic drain();
    @(negedge clk);
    in_word.valid = 1'b0;
    wait (steps_q.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup, then access; pready is tied high in the block
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel   = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr  = addr;
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    if (addr == ADDR_MODE) mode_sh = data[0];
    else if (addr == ADDR_EPS) eps_sh = data[30:0];
  endtask

  // random matrix, weighted toward plausible Delassus blocks
  function automatic mtx_t rand_mtx();
    mtx_t m;
    int   k;
    k = $urandom_range(0, 99);
    for (int i = 0; i < 9; i++) begin
      if (k < 60) begin
        if (i % 4 == 0) m.g[i] = $urandom_range(0, 32'h0004_0000);
        else m.g[i] = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      end else if (k < 80) begin
        m.g[i] = $urandom;
      end else if (k < 90) begin
        m.g[i] = $urandom_range(0, 16) - 32'd8;
      end else begin
        if (i % 4 == 0) m.g[i] = TOPV - $urandom_range(0, 32'h00FF_FFFF);
        else m.g[i] = $urandom;
      end
    end
    // most contact matrices are symmetric
    if (k < 60 && $urandom_range(0, 9) < 7) begin
      m.g[3] = m.g[1];
      m.g[6] = m.g[2];
      m.g[7] = m.g[5];
    end
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure at the falling edge, check at the rising
  // ---------------------------------------------------------------------------
  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("%0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  initial begin
    int hold;
    hold = 0;
    out_word.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_word.ready = 1'b0;
        hold--;
      end else begin
        out_word.ready = 1'b1;
        hold = idle_len();
      end
    end
  end

  steps_t head;
  always @(posedge clk) begin
    if (rst_n && out_word.valid && out_word.ready) begin
      if (steps_q.size() == 0) begin
        report("unexpected word rho_normal", out_word.rho_normal, '0);
      end else begin
        head = steps_q.pop_front();
        if (out_word.rho_normal !== head.rn)
          report("rho_normal", out_word.rho_normal, head.rn);
        if (out_word.rho_tangent_one !== head.rt1)
          report("rho_tangent_one", out_word.rho_tangent_one, head.rt1);
        if (out_word.rho_tangent_two !== head.rt2)
          report("rho_tangent_two", out_word.rho_tangent_two, head.rt2);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed rows, reset configuration (split mode, eps = 1 LSB).
  // Typed rows are the ones obvious by inspection.
  // ---------------------------------------------------------------------------
  localparam steps_t ALL_NEG  = '{Q_MINUS_ONE, Q_MINUS_ONE, Q_MINUS_ONE};
  localparam steps_t UNIT     = '{ONE_Q, ONE_Q, ONE_Q};
  localparam steps_t NO_STEPS = '{32'h0, 32'h0, 32'h0};

  drow_t dir_rows [14] = '{
    // zero matrix: G00 below eps -> whole word invalid
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, ALL_NEG},
    // identity: every step is 1.0
    '{'{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q}, 1'b1, UNIT},
    // tiny G00: reciprocal saturates
    '{'{2, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q}, 1'b1, '{TOPV, ONE_Q, ONE_Q}},
    // G00 equal to eps: invalid
    '{'{1, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q}, 1'b1, ALL_NEG},
    // G00 most negative: invalid
    '{'{BOTV, BOTV, BOTV, BOTV, BOTV, BOTV, BOTV, BOTV, BOTV}, 1'b1, ALL_NEG},
    // lower block zero: tangential invalid, normal kept
    '{'{ONE_Q, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{ONE_Q, Q_MINUS_ONE, Q_MINUS_ONE}},
    // all entries at the top
    '{'{TOPV, TOPV, TOPV, TOPV, TOPV, TOPV, TOPV, TOPV, TOPV}, 1'b0, NO_STEPS},
    // eigenvalue near 65536.0: step at zero or one LSB
    '{'{ONE_Q, 0, 0, 0, TOPV, TOPV, 0, TOPV, TOPV}, 1'b0, NO_STEPS},
    // antisymmetric coupling drops out
    '{'{ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, 0, 32'hFFFF_0000, ONE_Q}, 1'b0, NO_STEPS},
    // top diagonal, bottom off-diagonals
    '{'{TOPV, BOTV, BOTV, BOTV, TOPV, BOTV, BOTV, BOTV, TOPV}, 1'b0, NO_STEPS},
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, NO_STEPS},
    '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, NO_STEPS},
    // 2.0 diagonal, 0.5 coupling
    '{'{32'h2_0000, 32'h8000, 32'h8000, 32'h8000, 32'h2_0000, 32'h8000, 32'h8000,
        32'h8000, 32'h2_0000}, 1'b0, NO_STEPS},
    // negative lower block
    '{'{ONE_Q, 0, 0, 0, 32'hFFFE_0000, 0, 0, 0, 32'hFFFF_8000}, 1'b1,
      '{ONE_Q, Q_MINUS_ONE, Q_MINUS_ONE}}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mtx_t m;
    in_word.valid  = 1'b0;
    in_word.g_r0c0 = '0; in_word.g_r0c1 = '0; in_word.g_r0c2 = '0;
    in_word.g_r1c0 = '0; in_word.g_r1c1 = '0; in_word.g_r1c2 = '0;
    in_word.g_r2c0 = '0; in_word.g_r2c1 = '0; in_word.g_r2c2 = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      m.g = dir_rows[i].g;
      send_word(m, dir_rows[i].typed, dir_rows[i].want);
    end
    drain();

    // phases over register settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          reg_write(ADDR_MODE, 32'h1);
        end
        1: begin
          reg_write(ADDR_MODE, 32'hFFFF_FFFE);  // upper bits ignored -> split
          reg_write(ADDR_EPS, 32'h0);
        end
        2: begin
          reg_write(ADDR_MODE, 32'h1);
          reg_write(ADDR_EPS, 32'hFFFF_FFFF);   // bit 31 dropped -> max eps
        end
        3: begin
          reg_write(ADDR_EPS, ONE_Q);
        end
        4: begin
          reg_write(ADDR_MODE, 32'h0);
          reg_write(ADDR_EPS, $urandom_range(0, 32'h0002_0000));
        end
        5: begin
          reg_write(ADDR_MODE, 32'h1);
          reg_write(ADDR_EPS, $urandom);
        end
        default: begin
          reg_write(ADDR_MODE, 32'h0);
          reg_write(ADDR_EPS, 32'h1);
        end
      endcase
      quiet = (ph == 3);
      for (int n = 0; n < 62; n++) begin
        // let the pipe empty mid-phase once
        if (ph == 4 && n == 30) begin
          @(negedge clk);
          in_word.valid = 1'b0;
          wait (steps_q.size() == 0);
        end
        m = rand_mtx();
        send_word(m, 1'b0, NO_STEPS);
      end
      quiet = 1'b0;
      drain();
    end

    wait (steps_q.size() == 0);
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cssd_pkg.sv
hw/rtl/cssd_if.sv
hw/rtl/cssd_probe.sv
hw/rtl/cssd_recip.sv
hw/rtl/contact_step_size_from_delassus.sv
dv/tb_contact_step_size_from_delassus.sv
